// File: rtl/alks_pkg.sv
// Shared types, codes and reset constants for the actuator link keep-alive scheduler.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package alks_pkg;

  localparam int unsigned MaxFrames = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_DRIVE  = 3'd1,
    CMD_CATCH  = 3'd2,
    CMD_SHOVEL = 3'd3,
    CMD_LAMP   = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DRIVE   = 3'd0,
    REG_PASSING_POS = 3'd1,
    REG_NORMAL_POS  = 3'd2,
    REG_CATCH_DOWN  = 3'd3,
    REG_CATCH_UP    = 3'd4,
    REG_PING_IVL    = 3'd5,
    REG_SERVO_RPT   = 3'd6,
    REG_DRIVE_TMO   = 3'd7
  } reg_idx_e;

  localparam logic [7:0] OP_PING  = 8'h01;
  localparam logic [7:0] OP_SERVO = 8'h02;
  localparam logic [7:0] OP_DRIVE = 8'h03;
  localparam logic [7:0] OP_CATCH = 8'h04;
  localparam logic [7:0] OP_LIGHT = 8'h09;

  localparam logic [1:0] LEN_PING  = 2'd1;
  localparam logic [1:0] LEN_SHORT = 2'd2;
  localparam logic [1:0] LEN_DRIVE = 2'd3;

  localparam logic [6:0]  RST_MAX_DRIVE   = 7'd127;
  localparam logic [7:0]  RST_PASSING_POS = 8'd0;
  localparam logic [7:0]  RST_NORMAL_POS  = 8'd50;
  localparam logic [7:0]  RST_CATCH_DOWN  = 8'd0;
  localparam logic [7:0]  RST_CATCH_UP    = 8'd0;
  localparam logic [15:0] RST_PING_IVL    = 16'd100;
  localparam logic [15:0] RST_SERVO_RPT   = 16'd100;
  localparam logic [15:0] RST_DRIVE_TMO   = 16'd1000;
  localparam logic [7:0]  RST_LAST_POS    = 8'd50;

  typedef struct packed {
    logic [6:0]  max_drive;
    logic [7:0]  passing_position;
    logic [7:0]  normal_position;
    logic [7:0]  catch_down_position;
    logic [7:0]  catch_up_position;
    logic [15:0] ping_interval_ms;
    logic [15:0] servo_repeat_ms;
    logic [15:0] drive_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic [1:0] length;
  } frame_t;

  // Frames caused by one request, packed from slot 0 upwards.
  typedef struct packed {
    frame_t [MaxFrames-1:0] frames;
    logic [1:0]             count;
  } burst_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
    logic [1:0] count;
  } burst_status_t;

endpackage

// File: rtl/alks_cfg_regs.sv
// Configuration register file of the keep-alive scheduler.
// Depends on alks_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module alks_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [alks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [alks_pkg::CfgDataW-1:0]  cfg_data_i,
  output alks_pkg::cfg_t                 cfg_o
);
  import alks_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MAX_DRIVE:   cfg_d.max_drive           = cfg_data_i[6:0];
        REG_PASSING_POS: cfg_d.passing_position    = cfg_data_i[7:0];
        REG_NORMAL_POS:  cfg_d.normal_position     = cfg_data_i[7:0];
        REG_CATCH_DOWN:  cfg_d.catch_down_position = cfg_data_i[7:0];
        REG_CATCH_UP:    cfg_d.catch_up_position   = cfg_data_i[7:0];
        REG_PING_IVL:    cfg_d.ping_interval_ms    = cfg_data_i[15:0];
        REG_SERVO_RPT:   cfg_d.servo_repeat_ms     = cfg_data_i[15:0];
        REG_DRIVE_TMO:   cfg_d.drive_timeout_ms    = cfg_data_i[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_drive           <= RST_MAX_DRIVE;
      cfg_q.passing_position    <= RST_PASSING_POS;
      cfg_q.normal_position     <= RST_NORMAL_POS;
      cfg_q.catch_down_position <= RST_CATCH_DOWN;
      cfg_q.catch_up_position   <= RST_CATCH_UP;
      cfg_q.ping_interval_ms    <= RST_PING_IVL;
      cfg_q.servo_repeat_ms     <= RST_SERVO_RPT;
      cfg_q.drive_timeout_ms    <= RST_DRIVE_TMO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/alks_frame_gen.sv
// Frame builder: elapsed-time counters, last servo position and the frames of one request.
// Depends on alks_pkg for commands, opcodes, cfg_t and burst_t.
`timescale 1ns / 1ps

module alks_frame_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alks_pkg::cmd_e       cmd_i,
  input  logic signed [7:0]    left_speed_i,
  input  logic signed [7:0]    right_speed_i,
  input  logic                 flag_i,
  input  alks_pkg::cfg_t       cfg_i,
  input  logic                 take_i,
  output alks_pkg::burst_t     burst_o
);
  import alks_pkg::*;

  logic [15:0] ping_q, ping_d;
  logic [15:0] drive_q, drive_d;
  logic [15:0] servo_q, servo_d;
  logic [7:0]  last_pos_q, last_pos_d;
  logic [15:0] ping_inc, drive_inc, servo_inc;
  logic [7:0]  left_clamped, right_clamped;
  logic [7:0]  servo_pos;
  logic [1:0]  slot;
  burst_t      burst;

  // Limit a signed speed to plus or minus the configured magnitude.
  function automatic logic [7:0] clamp_speed(logic signed [7:0] s, logic [6:0] lim);
    logic signed [8:0] sx;
    logic signed [8:0] mx;
    logic signed [8:0] res;
    sx = {s[7], s};
    mx = {2'b00, lim};
    if (sx > mx) begin
      res = mx;
    end else if (sx < -mx) begin
      res = -mx;
    end else begin
      res = sx;
    end
    return res[7:0];
  endfunction

  assign ping_inc  = (ping_q  == 16'hFFFF) ? ping_q  : ping_q  + 16'd1;
  assign drive_inc = (drive_q == 16'hFFFF) ? drive_q : drive_q + 16'd1;
  assign servo_inc = (servo_q == 16'hFFFF) ? servo_q : servo_q + 16'd1;

  assign left_clamped  = clamp_speed(left_speed_i, cfg_i.max_drive);
  assign right_clamped = clamp_speed(right_speed_i, cfg_i.max_drive);
  assign servo_pos     = flag_i ? cfg_i.passing_position : cfg_i.normal_position;

  always_comb begin
    burst      = '0;
    slot       = 2'd0;
    ping_d     = ping_q;
    drive_d    = drive_q;
    servo_d    = servo_q;
    last_pos_d = last_pos_q;
    unique case (cmd_i)
      CMD_TICK: begin
        ping_d  = ping_inc;
        drive_d = drive_inc;
        servo_d = servo_inc;
        // Fixed order: ping, then zero drive, then servo repeat.
        if (ping_inc > cfg_i.ping_interval_ms) begin
          burst.frames[slot] = '{opcode: OP_PING, arg_a: 8'd0, arg_b: 8'd0, length: LEN_PING};
          ping_d = '0;
          slot   = slot + 2'd1;
        end
        if (drive_inc > cfg_i.drive_timeout_ms) begin
          burst.frames[slot] = '{opcode: OP_DRIVE, arg_a: 8'd0, arg_b: 8'd0,
                                 length: LEN_DRIVE};
          drive_d = '0;
          slot    = slot + 2'd1;
        end
        if (servo_inc > cfg_i.servo_repeat_ms) begin
          burst.frames[slot] = '{opcode: OP_SERVO, arg_a: last_pos_q, arg_b: 8'd0,
                                 length: LEN_SHORT};
          servo_d = '0;
          slot    = slot + 2'd1;
        end
        burst.count = slot;
      end
      CMD_DRIVE: begin
        burst.frames[0] = '{opcode: OP_DRIVE, arg_a: left_clamped, arg_b: right_clamped,
                            length: LEN_DRIVE};
        burst.count = 2'd1;
        drive_d     = '0;
      end
      CMD_CATCH: begin
        burst.frames[0] = '{opcode: OP_CATCH,
                            arg_a: flag_i ? cfg_i.catch_down_position
                                          : cfg_i.catch_up_position,
                            arg_b: 8'd0, length: LEN_SHORT};
        burst.count = 2'd1;
      end
      CMD_SHOVEL: begin
        burst.frames[0] = '{opcode: OP_SERVO, arg_a: servo_pos, arg_b: 8'd0,
                            length: LEN_SHORT};
        burst.count = 2'd1;
        last_pos_d  = servo_pos;
        servo_d     = '0;
      end
      CMD_LAMP: begin
        burst.frames[0] = '{opcode: OP_LIGHT, arg_a: {7'd0, flag_i}, arg_b: 8'd0,
                            length: LEN_SHORT};
        burst.count = 2'd1;
      end
      default: begin
        burst.count = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_q     <= '0;
      drive_q    <= '0;
      servo_q    <= '0;
      last_pos_q <= RST_LAST_POS;
    end else if (take_i) begin
      ping_q     <= ping_d;
      drive_q    <= drive_d;
      servo_q    <= servo_d;
      last_pos_q <= last_pos_d;
    end
  end

  assign burst_o = burst;

endmodule

// File: rtl/alks_burst_out.sv
// Result register: holds one request's frames and hands out one per cycle unless stalled.
// Depends on alks_pkg for burst_t, frame_t and burst_status_t.
`timescale 1ns / 1ps

module alks_burst_out (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  alks_pkg::burst_t        burst_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output alks_pkg::frame_t        frame_o,
  output logic                    last_o,
  output alks_pkg::burst_status_t status_o
);
  import alks_pkg::*;

  logic   valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  burst_t burst_q;
  logic   out_fire;

  assign last_o   = (idx_q == (burst_q.count - 2'd1));
  assign out_fire = valid_q && out_ready_i;
  // A new burst may enter as the final frame of the current one leaves.
  assign free_o   = !valid_q || (out_fire && last_o);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (out_fire) begin
      if (last_o) begin
        valid_d = 1'b0;
        idx_d   = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign out_valid_o = valid_q;
  assign frame_o     = burst_q.frames[idx_q];
  assign status_o    = '{valid: valid_q, idx: idx_q, count: burst_q.count};

endmodule

// File: rtl/actuator_link_keepalive_scheduler.sv
// Top level of the actuator link keep-alive scheduler: input register, frame builder,
// configuration registers and result register. Depends on alks_pkg and the alks_* modules.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  -------------------------------------
//  input     in         in_valid_i / in_ready_o    command, left/right speed, flag
//  output    out        out_valid_o / out_ready_i  opcode, arg_a, arg_b, length, last
//  config    in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// A request sits in the input register while its frames are built in a single pass; they
// enter the result register at the next edge, so the first frame is on the output in the
// cycle after the request is taken. The result register sends one frame per cycle while
// out_ready_i is high; a request waits in the input register until the last frame of the
// burst before it (up to three for a tick) leaves; one that makes no frame leaves at once.
// Reset clears the counters and the handshake state; no clearing pass is needed.
// A stalled output holds the result register, which in turn holds the input register.

module actuator_link_keepalive_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [alks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [alks_pkg::CfgDataW-1:0]  cfg_data_i,
  // Request channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     command_i,
  input  logic signed [7:0]              left_speed_i,
  input  logic signed [7:0]              right_speed_i,
  input  logic                           flag_i,
  // Frame channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     opcode_o,
  output logic [7:0]                     arg_a_o,
  output logic [7:0]                     arg_b_o,
  output logic [1:0]                     length_o,
  output logic                           last_o
);
  import alks_pkg::*;

  cfg_t              cfg;
  burst_t            burst;
  burst_status_t     burst_status;
  frame_t            frame;
  logic              burst_free;
  logic              take;
  logic              load;
  logic              in_fire;

  // Input register.
  logic              inq_valid_q;
  cmd_e              inq_cmd_q;
  logic signed [7:0] inq_left_q;
  logic signed [7:0] inq_right_q;
  logic              inq_flag_q;

  alks_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The held request leaves the input register once its frames can enter the result
  // register. A request with no frames (unknown command, tick with none due) leaves at once.
  assign take       = inq_valid_q && ((burst.count == 2'd0) || burst_free);
  assign load       = take && (burst.count != 2'd0);
  assign in_ready_o = !inq_valid_q || take;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_cmd_q   <= cmd_e'(command_i);
      inq_left_q  <= left_speed_i;
      inq_right_q <= right_speed_i;
      inq_flag_q  <= flag_i;
    end
  end

  alks_frame_gen u_frame_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (inq_cmd_q),
    .left_speed_i  (inq_left_q),
    .right_speed_i (inq_right_q),
    .flag_i        (inq_flag_q),
    .cfg_i         (cfg),
    .take_i        (take),
    .burst_o       (burst)
  );

  alks_burst_out u_burst_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (burst_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame),
    .last_o      (last_o),
    .status_o    (burst_status)
  );

  assign opcode_o = frame.opcode;
  assign arg_a_o  = frame.arg_a;
  assign arg_b_o  = frame.arg_b;
  assign length_o = frame.length;

`ifndef NO_ASSERTIONS
  // A held burst always has at least one frame and its pointer stays inside it.
  a_burst_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_status.valid |-> (burst_status.count != 2'd0) && (burst_status.idx < burst_status.count))
    else $error("burst pointer outside the held frames");

  // A frame taken that is not the last of its request is followed by another.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("frame burst ended without a last marker");

  // A request that produces frames shows one on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && (burst_status.idx == 2'd0))
    else $error("loaded burst not presented");

  // An empty input register never refuses a request.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inq_valid_q |-> in_ready_o)
    else $error("input stalled while the input register is empty");
`endif

endmodule

// File: test/alks_frame_checker.sv
// Frame checker for the actuator link keep-alive scheduler: it watches the register
// writes, the request channel and the frame channel, predicts and compares.
// Depends on alks_pkg for the command, register and frame codes.
`timescale 1ns / 1ps

module alks_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [alks_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [alks_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [2:0]                     command_i,
  input  logic signed [7:0]              left_speed_i,
  input  logic signed [7:0]              right_speed_i,
  input  logic                           flag_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [7:0]                     opcode_i,
  input  logic [7:0]                     arg_a_i,
  input  logic [7:0]                     arg_b_i,
  input  logic [1:0]                     length_i,
  input  logic                           last_i,
  output int                             frames_pending_o,
  output int                             frames_compared_o,
  output int                             mismatches_o
);
  import alks_pkg::*;

  typedef struct packed {
    frame_t frame;
    logic   last;
  } due_frame_t;

  due_frame_t  frames_due [$];
  cfg_t        cfg_q;
  logic [15:0] ping_ms, drive_ms, servo_ms;
  logic [7:0]  servo_pos;
  int          mismatches;
  int          frames_compared;

  assign mismatches_o      = mismatches;
  assign frames_compared_o = frames_compared;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic logic [15:0] bump(input logic [15:0] ms);
    return (ms == 16'hFFFF) ? ms : ms + 16'd1;
  endfunction

  function automatic logic [7:0] clamp_speed(input logic signed [7:0] speed);
    int v, lim;
    v   = speed;
    lim = cfg_q.max_drive;
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return 8'(v);
  endfunction

  function automatic frame_t make_frame(input logic [7:0] op, input logic [7:0] a,
                                        input logic [7:0] b, input logic [1:0] len);
    frame_t f;
    f.opcode = op;
    f.arg_a  = a;
    f.arg_b  = b;
    f.length = len;
    return f;
  endfunction

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_MAX_DRIVE:   cfg_q.max_drive           = data[6:0];
      REG_PASSING_POS: cfg_q.passing_position    = data[7:0];
      REG_NORMAL_POS:  cfg_q.normal_position     = data[7:0];
      REG_CATCH_DOWN:  cfg_q.catch_down_position = data[7:0];
      REG_CATCH_UP:    cfg_q.catch_up_position   = data[7:0];
      REG_PING_IVL:    cfg_q.ping_interval_ms    = data;
      REG_SERVO_RPT:   cfg_q.servo_repeat_ms     = data;
      REG_DRIVE_TMO:   cfg_q.drive_timeout_ms    = data;
      default: ;
    endcase
  endtask

  task automatic predict_frames(input logic [2:0] cmd, input logic signed [7:0] left,
                                input logic signed [7:0] right, input logic flag);
    frame_t     burst [$];
    due_frame_t d;
    case (cmd)
      CMD_TICK: begin
        ping_ms  = bump(ping_ms);
        drive_ms = bump(drive_ms);
        servo_ms = bump(servo_ms);
        if (ping_ms > cfg_q.ping_interval_ms) begin
          burst = {burst, make_frame(OP_PING, 8'd0, 8'd0, LEN_PING)};
          ping_ms = '0;
        end
        if (drive_ms > cfg_q.drive_timeout_ms) begin
          burst = {burst, make_frame(OP_DRIVE, 8'd0, 8'd0, LEN_DRIVE)};
          drive_ms = '0;
        end
        if (servo_ms > cfg_q.servo_repeat_ms) begin
          burst = {burst, make_frame(OP_SERVO, servo_pos, 8'd0, LEN_SHORT)};
          servo_ms = '0;
        end
      end
      CMD_DRIVE: begin
        burst = {burst, make_frame(OP_DRIVE, clamp_speed(left), clamp_speed(right),
                                   LEN_DRIVE)};
        drive_ms = '0;
      end
      CMD_CATCH: begin
        burst = {burst, make_frame(OP_CATCH, flag ? cfg_q.catch_down_position
                                                  : cfg_q.catch_up_position,
                                   8'd0, LEN_SHORT)};
      end
      CMD_SHOVEL: begin
        servo_pos = flag ? cfg_q.passing_position : cfg_q.normal_position;
        burst = {burst, make_frame(OP_SERVO, servo_pos, 8'd0, LEN_SHORT)};
        servo_ms = '0;
      end
      CMD_LAMP: begin
        burst = {burst, make_frame(OP_LIGHT, {7'd0, flag}, 8'd0, LEN_SHORT)};
      end
      default: ;
    endcase
    foreach (burst[k]) begin
      d.frame = burst[k];
      d.last  = (k == burst.size() - 1);
      frames_due = {frames_due, d};
    end
  endtask

  task automatic compare_frame();
    due_frame_t want;
    if (frames_due.size() == 0) begin
      report_mismatch("frame with nothing due (opcode)", 0, opcode_i);
      return;
    end
    want = frames_due.pop_front();
    frames_compared++;
    if (opcode_i !== want.frame.opcode) report_mismatch("opcode", want.frame.opcode, opcode_i);
    if (arg_a_i !== want.frame.arg_a)   report_mismatch("arg_a", want.frame.arg_a, arg_a_i);
    if (arg_b_i !== want.frame.arg_b)   report_mismatch("arg_b", want.frame.arg_b, arg_b_i);
    if (length_i !== want.frame.length) report_mismatch("length", want.frame.length, length_i);
    if (last_i !== want.last)           report_mismatch("last", want.last, last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_drive           = RST_MAX_DRIVE;
      cfg_q.passing_position    = RST_PASSING_POS;
      cfg_q.normal_position     = RST_NORMAL_POS;
      cfg_q.catch_down_position = RST_CATCH_DOWN;
      cfg_q.catch_up_position   = RST_CATCH_UP;
      cfg_q.ping_interval_ms    = RST_PING_IVL;
      cfg_q.servo_repeat_ms     = RST_SERVO_RPT;
      cfg_q.drive_timeout_ms    = RST_DRIVE_TMO;
      ping_ms   = '0;
      drive_ms  = '0;
      servo_ms  = '0;
      servo_pos = RST_LAST_POS;
      frames_due.delete();
      frames_pending_o <= 0;
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        predict_frames(command_i, left_speed_i, right_speed_i, flag_i);
      end
      if (out_valid_i && out_ready_i) compare_frame();
      frames_pending_o <= frames_due.size();
    end
  end

  initial begin
    mismatches      = 0;
    frames_compared = 0;
  end

endmodule

// File: test/tb_top.sv
// Top of the testbench for the actuator link keep-alive scheduler: clock, reset, register
// settings and requests, with alks_frame_checker doing the prediction and comparison.
// Depends on alks_pkg, alks_frame_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import alks_pkg::*;

  // A request that makes no frame leaves the block at the edge after it is taken, so the
  // settle time below is plenty to let it pass right through.
  localparam int SETTLE_CYCLES = 8;
  // The run sends some five hundred requests of at most three frames each; even under
  // the random stalls this limit leaves a wide margin.
  localparam int CYCLE_LIMIT   = 50_000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 45;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          command_i = '0;
  logic signed [7:0]   left_speed_i = '0;
  logic signed [7:0]   right_speed_i = '0;
  logic                flag_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          opcode_o;
  logic [7:0]          arg_a_o;
  logic [7:0]          arg_b_o;
  logic [1:0]          length_o;
  logic                last_o;

  int frames_pending, frames_compared, mismatches;
  int cycle_count = 0;
  int requests_sent = 0;
  int ignored_sent = 0;
  int settings_used = 1;

  // While calm is set neither side idles, which gives a long stretch at full rate.
  logic calm = 1'b0;

  // Values for the eight registers, indexed by register; loaded by program_registers.
  logic [15:0] setting [8];

  always #5 clk_i = ~clk_i;

  actuator_link_keepalive_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .left_speed_i  (left_speed_i),
    .right_speed_i (right_speed_i),
    .flag_i        (flag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .opcode_o      (opcode_o),
    .arg_a_o       (arg_a_o),
    .arg_b_o       (arg_b_o),
    .length_o      (length_o),
    .last_o        (last_o)
  );

  alks_frame_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .command_i         (command_i),
    .left_speed_i      (left_speed_i),
    .right_speed_i     (right_speed_i),
    .flag_i            (flag_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .opcode_i          (opcode_o),
    .arg_a_i           (arg_a_o),
    .arg_b_i           (arg_b_o),
    .length_i          (length_o),
    .last_i            (last_o),
    .frames_pending_o  (frames_pending),
    .frames_compared_o (frames_compared),
    .mismatches_o      (mismatches)
  );

  // The frame receiver stalls in about 17 percent of cycles, except in the calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 17);
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d frames still due.",
               cycle_count, frames_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. The task is always entered
  // at a rising edge; afterwards valid may drop for a random gap. When there is no gap the
  // next call raises valid again in the same step, which is its only assignment there.
  task automatic send_request(input logic [2:0] cmd, input logic [7:0] left,
                              input logic [7:0] right, input logic flag);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    left_speed_i  <= left;
    right_speed_i <= right;
    flag_i        <= flag;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    if (cmd > CMD_LAMP) ignored_sent++;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Waits until every predicted frame has come back, then lets the pipeline settle so
  // that requests which made no frame have certainly left the block.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes all eight registers back to back; only ever called with the block idle.
  task automatic program_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= setting[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_interval();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // A speed from the extremes now and then, otherwise any byte.
  function automatic logic [7:0] pick_speed();
    case ($urandom_range(0, 5))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random request. Ticks dominate so that the counters keep firing; a small share
  // of requests carry the unused command codes, which the block must simply drop.
  task automatic send_random_request();
    logic [2:0] cmd;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      cmd = CMD_TICK;
    else if (pick < 65) cmd = CMD_DRIVE;
    else if (pick < 75) cmd = CMD_CATCH;
    else if (pick < 85) cmd = CMD_SHOVEL;
    else if (pick < 95) cmd = CMD_LAMP;
    else                cmd = 3'($urandom_range(CMD_LAMP + 1, 7));
    send_request(cmd, pick_speed(), pick_speed(), 1'($urandom));
  endtask

  initial begin
    int useful;
    logic [6:0] max_speed;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests under the reset settings: speeds at both ends, every command
    // with both flag values, and the unused codes, which must give no frames at all.
    send_request(CMD_DRIVE, 8'h7F, 8'h7F, 1'b0);
    send_request(CMD_DRIVE, 8'h80, 8'h80, 1'b1);
    send_request(CMD_DRIVE, 8'h00, 8'h00, 1'b0);
    send_request(CMD_DRIVE, 8'hFF, 8'h01, 1'b0);
    send_request(CMD_CATCH, 8'h00, 8'h00, 1'b0);
    send_request(CMD_CATCH, 8'hFF, 8'hFF, 1'b1);
    send_request(CMD_SHOVEL, 8'h00, 8'h00, 1'b1);
    send_request(CMD_SHOVEL, 8'h00, 8'h00, 1'b0);
    send_request(CMD_LAMP, 8'h00, 8'h00, 1'b0);
    send_request(CMD_LAMP, 8'h00, 8'h00, 1'b1);
    for (int c = CMD_LAMP + 1; c < 8; c++) send_request(3'(c), 8'hFF, 8'hFF, 1'b1);
    send_request(CMD_TICK, 8'h00, 8'h00, 1'b0);
    send_request(CMD_TICK, 8'hFF, 8'hFF, 1'b1);
    drain();

    // Short intervals so that ticks fire: a ping on every tick, the servo repeat every
    // second tick and the zero drive every third, so their order within a tick shows up.
    // A small speed limit checks clamping on both sides at once.
    setting[REG_MAX_DRIVE]   = 16'd5;
    setting[REG_PASSING_POS] = 16'h00FF;
    setting[REG_NORMAL_POS]  = 16'h00A5;
    setting[REG_CATCH_DOWN]  = 16'h000F;
    setting[REG_CATCH_UP]    = 16'h00F0;
    setting[REG_PING_IVL]    = 16'd0;
    setting[REG_SERVO_RPT]   = 16'd1;
    setting[REG_DRIVE_TMO]   = 16'd2;
    program_registers();
    send_request(CMD_DRIVE, 8'h7F, 8'h80, 1'b0);
    send_request(CMD_CATCH, 8'h00, 8'h00, 1'b1);
    send_request(CMD_SHOVEL, 8'h00, 8'h00, 1'b1);
    repeat (6) send_request(CMD_TICK, 8'h00, 8'h00, 1'b0);
    drain();

    // Random phases, each under fresh register values. The speed limit visits both ends
    // and the intervals mix zero, the maximum and small values. Upper data bits beyond a
    // register's width are random and must be dropped. Two phases run without idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 3)
        0:       max_speed = 7'd0;
        1:       max_speed = 7'd127;
        default: max_speed = 7'($urandom);
      endcase
      setting[REG_MAX_DRIVE]   = {9'($urandom), max_speed};
      setting[REG_PASSING_POS] = 16'($urandom);
      setting[REG_NORMAL_POS]  = 16'($urandom);
      setting[REG_CATCH_DOWN]  = 16'($urandom);
      setting[REG_CATCH_UP]    = 16'($urandom);
      setting[REG_PING_IVL]    = pick_interval();
      setting[REG_SERVO_RPT]   = pick_interval();
      setting[REG_DRIVE_TMO]   = pick_interval();
      program_registers();
      calm   = (phase == 4 || phase == 5);
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        send_random_request();
        if (command_i <= CMD_LAMP) useful++;
      end
      drain();
      calm = 1'b0;
    end

    $display("Sent %0d requests (%0d with unused codes) under %0d register settings,",
             requests_sent, ignored_sent, settings_used);
    $display("covering every command, speed clamping and the timed frames; %0d compared.",
             frames_compared);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
